[hdl/ladrc_pkg.sv]
// ladrc_pkg: shared constants, operand and opcode codes and the step program
// of the linear disturbance rejection controller
// depends on nothing; used by every module of the block
package ladrc_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int STATE_W     = 48;
	localparam int DRIVE_LIMIT = 7000;
	localparam int DRIVE_W     = 30;
	localparam int DRIVE_MAG_W = DRIVE_W - 1;
	localparam int DEN_W       = 26;
	localparam int DVD_W       = STATE_W + FRAC_BITS;
	localparam int HALF_W      = STATE_W / 2;

	localparam logic [DVD_W-1:0] DRIVE_LIM_Q = DVD_W'(DRIVE_LIMIT) << FRAC_BITS;
	localparam logic signed [STATE_W-1:0] SMAX = {1'b0, {(STATE_W-1){1'b1}}};
	localparam logic signed [STATE_W-1:0] SMIN = {1'b1, {(STATE_W-1){1'b0}}};

	// register indexes of the configuration port
	localparam logic [2:0] CFG_STEP_SIZE  = 3'd0;
	localparam logic [2:0] CFG_TRACK_GAIN = 3'd1;
	localparam logic [2:0] CFG_CTRL_BW    = 3'd2;
	localparam logic [2:0] CFG_OBS_BW     = 3'd3;
	localparam logic [2:0] CFG_PLANT_GAIN = 3'd4;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2
	} op_t;

	typedef enum logic [4:0] {
		S_ZERO  = 5'd0,
		S_R     = 5'd1,
		S_R2    = 5'd2,
		S_H     = 5'd3,
		S_W0    = 5'd4,
		S_B1    = 5'd5,
		S_WC    = 5'd6,
		S_KD    = 5'd7,
		S_B0    = 5'd8,
		S_SP    = 5'd9,
		S_MEAS  = 5'd10,
		S_LD    = 5'd11,
		S_RPOS  = 5'd12,
		S_RVEL  = 5'd13,
		S_EPOS  = 5'd14,
		S_EVEL  = 5'd15,
		S_EDIST = 5'd16,
		S_T0    = 5'd17,
		S_T1    = 5'd18,
		S_T2    = 5'd19
	} src_t;

	typedef enum logic [2:0] {
		D_T0    = 3'd0,
		D_T1    = 3'd1,
		D_T2    = 3'd2,
		D_RPOS  = 3'd3,
		D_RVEL  = 3'd4,
		D_EPOS  = 3'd5,
		D_EVEL  = 3'd6,
		D_EDIST = 3'd7
	} dst_t;

	typedef struct packed {
		op_t  op;
		src_t a;
		src_t b;
		dst_t dst;
	} step_t;

	localparam logic [5:0] LAST_PC = 6'd34;

	// one control step as a list of operations on the shared units
	function automatic step_t prog(input logic [5:0] pc);
		step_t s;
		case (pc)
			// tracking differentiator
			6'd0:  s = '{OP_MUL, S_R,     S_R,     D_T0};
			6'd1:  s = '{OP_SUB, S_RPOS,  S_SP,    D_T1};
			6'd2:  s = '{OP_MUL, S_T0,    S_T1,    D_T0};
			6'd3:  s = '{OP_SUB, S_ZERO,  S_T0,    D_T0};
			6'd4:  s = '{OP_MUL, S_R2,    S_RVEL,  D_T1};
			6'd5:  s = '{OP_SUB, S_T0,    S_T1,    D_T0};
			6'd6:  s = '{OP_MUL, S_RVEL,  S_H,     D_T1};
			6'd7:  s = '{OP_ADD, S_RPOS,  S_T1,    D_RPOS};
			6'd8:  s = '{OP_MUL, S_T0,    S_H,     D_T1};
			6'd9:  s = '{OP_ADD, S_RVEL,  S_T1,    D_RVEL};
			// observer: error, then position, velocity, disturbance
			6'd10: s = '{OP_SUB, S_EPOS,  S_MEAS,  D_T0};
			6'd11: s = '{OP_MUL, S_B1,    S_T0,    D_T1};
			6'd12: s = '{OP_SUB, S_EVEL,  S_T1,    D_T1};
			6'd13: s = '{OP_MUL, S_T1,    S_H,     D_T1};
			6'd14: s = '{OP_ADD, S_EPOS,  S_T1,    D_EPOS};
			6'd15: s = '{OP_MUL, S_B1,    S_W0,    D_T1};
			6'd16: s = '{OP_MUL, S_T1,    S_T0,    D_T1};
			6'd17: s = '{OP_SUB, S_EDIST, S_T1,    D_T1};
			6'd18: s = '{OP_MUL, S_B0,    S_LD,    D_T2};
			6'd19: s = '{OP_ADD, S_T1,    S_T2,    D_T1};
			6'd20: s = '{OP_MUL, S_T1,    S_H,     D_T1};
			6'd21: s = '{OP_ADD, S_EVEL,  S_T1,    D_EVEL};
			6'd22: s = '{OP_MUL, S_W0,    S_W0,    D_T1};
			6'd23: s = '{OP_MUL, S_T1,    S_W0,    D_T1};
			6'd24: s = '{OP_MUL, S_T1,    S_T0,    D_T1};
			6'd25: s = '{OP_SUB, S_ZERO,  S_T1,    D_T1};
			6'd26: s = '{OP_MUL, S_T1,    S_H,     D_T1};
			6'd27: s = '{OP_ADD, S_EDIST, S_T1,    D_EDIST};
			// pd law and disturbance compensation numerator
			6'd28: s = '{OP_SUB, S_RPOS,  S_EPOS,  D_T0};
			6'd29: s = '{OP_MUL, S_WC,    S_WC,    D_T1};
			6'd30: s = '{OP_MUL, S_T1,    S_T0,    D_T0};
			6'd31: s = '{OP_SUB, S_RVEL,  S_EVEL,  D_T1};
			6'd32: s = '{OP_MUL, S_KD,    S_T1,    D_T1};
			6'd33: s = '{OP_ADD, S_T0,    S_T1,    D_T0};
			6'd34: s = '{OP_SUB, S_T0,    S_EDIST, D_T0};
			default: s = '{OP_ADD, S_ZERO, S_ZERO, D_T2};
		endcase
		return s;
	endfunction

endpackage

[hdl/ladrc_mul.sv]
// ladrc_mul: shared saturating fixed-point multiplier, one half-width
// partial product a cycle, result scaled down and saturated to state range
// depends on ladrc_pkg
module ladrc_mul (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [ladrc_pkg::STATE_W-1:0]  a,
	input  logic signed [ladrc_pkg::STATE_W-1:0]  b,
	output logic                                  done,
	output logic signed [ladrc_pkg::STATE_W-1:0]  p
);

	localparam int W  = ladrc_pkg::STATE_W;
	localparam int HW = ladrc_pkg::HALF_W;
	localparam int AW = 2 * W;
	localparam int RW = AW - ladrc_pkg::FRAC_BITS;

	logic [W-1:0]     ma_q, mb_q;
	logic             neg_q;
	logic             busy_q;
	logic             done_q;
	logic [2:0]       cnt_q;
	logic [AW-1:0]    acc_q;
	logic [W-1:0]     prod_s1;
	logic [1:0]       sh_s1;
	logic [HW-1:0]    op_a, op_b;
	logic [1:0]       sh_next;
	logic [AW-1:0]    addend;
	logic [RW-1:0]    rs;
	logic             big;

	// partial product operand selection
	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin op_a = ma_q[HW-1:0]; op_b = mb_q[HW-1:0]; sh_next = 2'd0; end
			2'd1: begin op_a = ma_q[HW-1:0]; op_b = mb_q[W-1:HW]; sh_next = 2'd1; end
			2'd2: begin op_a = ma_q[W-1:HW]; op_b = mb_q[HW-1:0]; sh_next = 2'd1; end
			default: begin op_a = ma_q[W-1:HW]; op_b = mb_q[W-1:HW]; sh_next = 2'd2; end
		endcase
	end

	// aligned partial product
	always_comb begin
		case (sh_s1)
			2'd0:    addend = AW'(prod_s1);
			2'd1:    addend = AW'(prod_s1) << HW;
			default: addend = AW'(prod_s1) << W;
		endcase
	end

	// sequence of four partial products and their accumulation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= a[W-1] ? W'(-a) : W'(a);
			mb_q  <= b[W-1] ? W'(-b) : W'(b);
			neg_q <= a[W-1] ^ b[W-1];
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q <= 3'd3) begin
				prod_s1 <= op_a * op_b;
				sh_s1   <= sh_next;
			end
			if (cnt_q >= 3'd1) begin
				acc_q <= acc_q + addend;
			end
		end
	end

	// scale, then saturate to the signed state range
	assign rs  = acc_q[AW-1:ladrc_pkg::FRAC_BITS];
	assign big = |rs[RW-1:W-1];

	always_comb begin
		if (!neg_q) begin
			p = big ? ladrc_pkg::SMAX : $signed({1'b0, rs[W-2:0]});
		end else begin
			p = big ? ladrc_pkg::SMIN : $signed(-rs[W-1:0]);
		end
	end

	assign done = done_q;

endmodule

[hdl/ladrc_div.sv]
// ladrc_div: restoring divider, one quotient bit a cycle, giving the drive
// magnitude (magnitude << frac) / gain limited to the drive limit
// depends on ladrc_pkg
module ladrc_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [ladrc_pkg::STATE_W-1:0]         mag,
	input  logic [ladrc_pkg::DEN_W-1:0]           den,
	output logic                                  done,
	output logic [ladrc_pkg::DRIVE_MAG_W-1:0]     quot,
	output logic                                  clamp
);

	localparam int DW = ladrc_pkg::DVD_W;
	localparam int NW = ladrc_pkg::DEN_W;

	logic            busy_q;
	logic            done_q;
	logic [6:0]      cnt_q;
	logic [DW-1:0]   dvd_q;
	logic [DW-1:0]   quo_q;
	logic [NW-1:0]   rem_q;
	logic [NW:0]     trial;
	logic            fits;

	assign trial = {rem_q, dvd_q[DW-1]};
	assign fits  = trial >= {1'b0, den};

	// bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one restoring step a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {mag, {ladrc_pkg::FRAC_BITS{1'b0}}};
			quo_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			quo_q <= {quo_q[DW-2:0], fits};
			rem_q <= fits ? NW'(trial - {1'b0, den}) : trial[NW-1:0];
		end
	end

	assign clamp = quo_q > ladrc_pkg::DRIVE_LIM_Q;
	assign quot  = clamp ? ladrc_pkg::DRIVE_LIM_Q[ladrc_pkg::DRIVE_MAG_W-1:0]
	                     : quo_q[ladrc_pkg::DRIVE_MAG_W-1:0];
	assign done  = done_q;

endmodule

[hdl/linear_adrc_controller.sv]
// linear_adrc_controller: top level, sequencer, state registers and output stage
// depends on ladrc_pkg, ladrc_mul and ladrc_div
//
// One transaction on the input runs one control step: tracking differentiator,
// extended state observer and pd law, evaluated as 35 operations on a shared
// saturating adder and a shared multiplier that holds the sequencer while it
// forms each product from four half-width partial products, followed by a
// 64-step bit-serial divider for the division by the plant gain. The 35
// operations are 18 products and 17 additions or subtractions; a run step then
// passes through the division state and the output state back to idle. A clear
// command goes straight to the output state. The input is not ready while a
// step is under way. The result sits in an output register so a new
// transaction may be taken while it waits; a finished step waits for that
// register to drain before it is delivered.
module linear_adrc_controller (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [25:0] cfg_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // setpoint [31:0], measurement [63:32]
	input  logic [0:0]  s_tuser,   // cmd [0]
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // drive [29:0], zero fill [31:30]
	output logic [0:0]  m_tuser    // clamped [0]
);

	localparam int W  = ladrc_pkg::STATE_W;
	localparam int DW = ladrc_pkg::DRIVE_W;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EXEC = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t state_q;

	logic [15:0] step_size_q;
	logic [25:0] track_gain_q, ctrl_bw_q, obs_bw_q, plant_gain_q;

	logic signed [W-1:0] ref_pos_q, ref_vel_q, est_pos_q, est_vel_q, est_dist_q;
	logic signed [W-1:0] t0_q, t1_q, t2_q;
	logic signed [DW-1:0] last_drive_q;
	logic signed [31:0]   sp_q, meas_q;
	logic [5:0]           pc_q;
	logic                 div_go_q;

	logic signed [DW-1:0] res_drive_q, drive_q;
	logic                 res_clamp_q, clamp_q, m_valid_q;

	ladrc_pkg::step_t     cur;
	logic signed [W-1:0]  a_val, b_val, as_val, wb_val, mul_p;
	logic                 mul_start, mul_done, div_done, div_clamp;
	logic [ladrc_pkg::DRIVE_MAG_W-1:0] div_quot;
	logic [ladrc_pkg::DEN_W-1:0]       b0_eff;
	logic [W-1:0]         num_mag;
	logic                 wb_en, out_free;
	logic signed [DW-1:0] drive_res;

	function automatic logic signed [W-1:0] operand(input ladrc_pkg::src_t sel,
		input logic signed [W-1:0] r, r2, h, w0, b1, wc, kd, b0, sp, ms, ld,
		input logic signed [W-1:0] rp, rv, ep, ev, ed, x0, x1, x2);
		logic signed [W-1:0] v;
		case (sel)
			ladrc_pkg::S_ZERO:  v = '0;
			ladrc_pkg::S_R:     v = r;
			ladrc_pkg::S_R2:    v = r2;
			ladrc_pkg::S_H:     v = h;
			ladrc_pkg::S_W0:    v = w0;
			ladrc_pkg::S_B1:    v = b1;
			ladrc_pkg::S_WC:    v = wc;
			ladrc_pkg::S_KD:    v = kd;
			ladrc_pkg::S_B0:    v = b0;
			ladrc_pkg::S_SP:    v = sp;
			ladrc_pkg::S_MEAS:  v = ms;
			ladrc_pkg::S_LD:    v = ld;
			ladrc_pkg::S_RPOS:  v = rp;
			ladrc_pkg::S_RVEL:  v = rv;
			ladrc_pkg::S_EPOS:  v = ep;
			ladrc_pkg::S_EVEL:  v = ev;
			ladrc_pkg::S_EDIST: v = ed;
			ladrc_pkg::S_T0:    v = x0;
			ladrc_pkg::S_T1:    v = x1;
			ladrc_pkg::S_T2:    v = x2;
			default:            v = '0;
		endcase
		return v;
	endfunction

	// saturating add or subtract on the state range
	function automatic logic signed [W-1:0] sat_as(input logic signed [W-1:0] a, b,
		input logic sub);
		logic signed [W:0] s;
		s = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
		if (s[W] != s[W-1]) begin
			return s[W] ? ladrc_pkg::SMIN : ladrc_pkg::SMAX;
		end
		return s[W-1:0];
	endfunction

	assign b0_eff = (plant_gain_q == '0) ? 26'd1 : plant_gain_q;

	// operand selection for the current operation
	assign cur   = ladrc_pkg::prog(pc_q);
	assign a_val = operand(cur.a,
		W'(track_gain_q), W'({track_gain_q, 1'b0}), W'(step_size_q), W'(obs_bw_q),
		W'({obs_bw_q, 1'b0}) + W'(obs_bw_q), W'(ctrl_bw_q), W'({ctrl_bw_q, 1'b0}),
		W'(b0_eff), W'(sp_q), W'(meas_q), W'(last_drive_q),
		ref_pos_q, ref_vel_q, est_pos_q, est_vel_q, est_dist_q, t0_q, t1_q, t2_q);
	assign b_val = operand(cur.b,
		W'(track_gain_q), W'({track_gain_q, 1'b0}), W'(step_size_q), W'(obs_bw_q),
		W'({obs_bw_q, 1'b0}) + W'(obs_bw_q), W'(ctrl_bw_q), W'({ctrl_bw_q, 1'b0}),
		W'(b0_eff), W'(sp_q), W'(meas_q), W'(last_drive_q),
		ref_pos_q, ref_vel_q, est_pos_q, est_vel_q, est_dist_q, t0_q, t1_q, t2_q);

	assign as_val    = sat_as(a_val, b_val, cur.op == ladrc_pkg::OP_SUB);
	assign mul_start = (state_q == ST_EXEC) && (cur.op == ladrc_pkg::OP_MUL);
	assign wb_en     = ((state_q == ST_EXEC) && (cur.op != ladrc_pkg::OP_MUL)) ||
	                   ((state_q == ST_MUL) && mul_done);
	assign wb_val    = (state_q == ST_MUL) ? mul_p : as_val;

	ladrc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (a_val),
		.b      (b_val),
		.done   (mul_done),
		.p      (mul_p)
	);

	assign num_mag = t0_q[W-1] ? W'(-t0_q) : W'(t0_q);

	ladrc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_q),
		.mag    (num_mag),
		.den    (b0_eff),
		.done   (div_done),
		.quot   (div_quot),
		.clamp  (div_clamp)
	);

	assign drive_res = t0_q[W-1] ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
	assign out_free  = !m_valid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_size_q  <= 16'd66;
			track_gain_q <= 26'd1310720;
			ctrl_bw_q    <= 26'd2162688;
			obs_bw_q     <= 26'd8716288;
			plant_gain_q <= 26'd524288;
		end else if (cfg_we) begin
			case (cfg_index)
				ladrc_pkg::CFG_STEP_SIZE:  step_size_q  <= cfg_data[15:0];
				ladrc_pkg::CFG_TRACK_GAIN: track_gain_q <= cfg_data;
				ladrc_pkg::CFG_CTRL_BW:    ctrl_bw_q    <= cfg_data;
				ladrc_pkg::CFG_OBS_BW:     obs_bw_q     <= cfg_data;
				ladrc_pkg::CFG_PLANT_GAIN: plant_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pc_q         <= '0;
			div_go_q     <= 1'b0;
			ref_pos_q    <= '0;
			ref_vel_q    <= '0;
			est_pos_q    <= '0;
			est_vel_q    <= '0;
			est_dist_q   <= '0;
			last_drive_q <= '0;
		end else begin
			div_go_q <= 1'b0;
			if (wb_en) begin
				case (cur.dst)
					ladrc_pkg::D_T0:    t0_q       <= wb_val;
					ladrc_pkg::D_T1:    t1_q       <= wb_val;
					ladrc_pkg::D_T2:    t2_q       <= wb_val;
					ladrc_pkg::D_RPOS:  ref_pos_q  <= wb_val;
					ladrc_pkg::D_RVEL:  ref_vel_q  <= wb_val;
					ladrc_pkg::D_EPOS:  est_pos_q  <= wb_val;
					ladrc_pkg::D_EVEL:  est_vel_q  <= wb_val;
					default:            est_dist_q <= wb_val;
				endcase
				pc_q <= pc_q + 6'd1;
				if (pc_q == ladrc_pkg::LAST_PC) begin
					state_q  <= ST_DIV;
					div_go_q <= 1'b1;
				end else begin
					state_q <= ST_EXEC;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						sp_q   <= s_tdata[31:0];
						meas_q <= s_tdata[63:32];
						pc_q   <= '0;
						if (s_tuser[0]) begin
							est_pos_q   <= '0;
							est_vel_q   <= '0;
							est_dist_q  <= '0;
							res_drive_q <= last_drive_q;
							res_clamp_q <= 1'b0;
							state_q     <= ST_OUT;
						end else begin
							state_q <= ST_EXEC;
						end
					end
				end
				ST_EXEC: begin
					if (cur.op == ladrc_pkg::OP_MUL) begin
						state_q <= ST_MUL;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						res_drive_q  <= drive_res;
						res_clamp_q  <= div_clamp;
						last_drive_q <= drive_res;
						state_q      <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			drive_q <= res_drive_q;
			clamp_q <= res_clamp_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, drive_q};
	assign m_tuser  = clamp_q;

	// a product completes only while the sequencer waits for it
	a_mul_done: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> state_q == ST_MUL)
		else $error("multiplier result outside its wait state");

	// the divider is started only on entry to the division state
	a_div_go: assert property (@(posedge clk) disable iff (!arst_n)
		div_go_q |-> state_q == ST_DIV && $past(state_q) != ST_DIV)
		else $error("divider start outside division entry");

	// a flagged result sits exactly at the limit
	a_clamp_lim: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && clamp_q) |->
		(drive_q == DW'(ladrc_pkg::DRIVE_LIM_Q) || drive_q == -DW'(ladrc_pkg::DRIVE_LIM_Q)))
		else $error("clamped drive not at the limit");

endmodule

[verif/linear_adrc_controller_tb.sv]
// linear_adrc_controller_tb: self-checking bench for the fixed-point adrc controller
// depends on ladrc_pkg and linear_adrc_controller; drives steps and clears, checks drive and clamp
module linear_adrc_controller_tb;

	localparam int IDLE_LIMIT = 20000;
	localparam logic CMD_RUN   = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [31:0] setpoint;
		logic [31:0] measurement;
	} ctrl_item_t;

	typedef struct packed {
		logic [29:0] drive;
		logic        clamped;
	} drive_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [25:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [63:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [0:0] m_tuser;

	// predictor state and configuration
	logic signed [63:0] m_rpos, m_rvel, m_epos, m_evel, m_edist, m_last;
	logic [63:0] c_h, c_r, c_wc, c_w0, c_b0;

	ctrl_item_t pending_items[$];
	drive_res_t expected_drives[$];
	int mismatches = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_phase = 0;
	int stall_len = 3;
	bit stim_done = 0;
	bit hold_sender = 0;

	linear_adrc_controller DUT (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'(ladrc_pkg::SMAX)) return 64'(ladrc_pkg::SMAX);
		if (s < 65'(ladrc_pkg::SMIN)) return 64'(ladrc_pkg::SMIN);
		return 64'(s);
	endfunction

	function automatic logic signed [63:0] sat_sub(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) - 65'(b);
		if (s > 65'(ladrc_pkg::SMAX)) return 64'(ladrc_pkg::SMAX);
		if (s < 65'(ladrc_pkg::SMIN)) return 64'(ladrc_pkg::SMIN);
		return 64'(s);
	endfunction

	// exact product, magnitude truncated then saturated
	function automatic logic signed [63:0] fx_mul(logic signed [63:0] a, logic signed [63:0] b);
		logic [63:0] ma, mb;
		logic [127:0] p;
		logic neg;
		neg = (a < 0) != (b < 0);
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		p = (128'(ma) * 128'(mb)) >> ladrc_pkg::FRAC_BITS;
		if (!neg) return (p > 128'(ladrc_pkg::SMAX)) ? 64'(ladrc_pkg::SMAX) : 64'(p);
		return (p >= (128'(1) << (ladrc_pkg::STATE_W - 1))) ? 64'(ladrc_pkg::SMIN) : -64'(p);
	endfunction

	function automatic drive_res_t predict_drive(ctrl_item_t it);
		drive_res_t res;
		logic signed [63:0] sp, ms, fh, e, b1, b2, b3, n1, n2, n3, u0, num, q;
		logic [63:0] mag, qhi, rem, uq, lim, b0;
		res.clamped = 1'b0;
		if (it.cmd == CMD_CLEAR) begin
			m_epos = 0; m_evel = 0; m_edist = 0;
			res.drive = m_last[29:0];
			return res;
		end
		sp = 64'(signed'(it.setpoint));
		ms = 64'(signed'(it.measurement));
		b0 = (c_b0 == 0) ? 64'd1 : c_b0;
		// tracking differentiator
		fh = sat_sub(sat_sub(0, fx_mul(fx_mul(c_r, c_r), sat_sub(m_rpos, sp))),
			fx_mul(2 * c_r, m_rvel));
		m_rpos = sat_add(m_rpos, fx_mul(m_rvel, c_h));
		m_rvel = sat_add(m_rvel, fx_mul(fh, c_h));
		// observer
		b1 = 3 * c_w0;
		b2 = fx_mul(b1, c_w0);
		b3 = fx_mul(fx_mul(c_w0, c_w0), c_w0);
		e = sat_sub(m_epos, ms);
		n1 = sat_add(m_epos, fx_mul(sat_sub(m_evel, fx_mul(b1, e)), c_h));
		n2 = sat_add(m_evel, fx_mul(sat_add(sat_sub(m_edist, fx_mul(b2, e)),
			fx_mul(b0, m_last)), c_h));
		n3 = sat_add(m_edist, fx_mul(sat_sub(0, fx_mul(b3, e)), c_h));
		m_epos = n1; m_evel = n2; m_edist = n3;
		// pd law and division
		u0 = sat_add(fx_mul(fx_mul(c_wc, c_wc), sat_sub(m_rpos, m_epos)),
			fx_mul(2 * c_wc, sat_sub(m_rvel, m_evel)));
		num = sat_sub(u0, m_edist);
		lim = 64'(ladrc_pkg::DRIVE_LIMIT) << ladrc_pkg::FRAC_BITS;
		mag = num < 0 ? -num : num;
		qhi = mag / b0;
		rem = mag % b0;
		if (qhi > ladrc_pkg::DRIVE_LIMIT) begin
			uq = lim;
			res.clamped = 1'b1;
		end else begin
			uq = (qhi << ladrc_pkg::FRAC_BITS) + ((rem << ladrc_pkg::FRAC_BITS) / b0);
			if (uq > lim) begin
				uq = lim;
				res.clamped = 1'b1;
			end
		end
		q = num < 0 ? -uq : uq;
		m_last = 64'(signed'(q[31:0]));
		res.drive = q[29:0];
		return res;
	endfunction

	function automatic logic [31:0] rand_word(int mode);
		case (mode)
			0: return $urandom;
			1: return 32'($urandom_range(0, 65536 * 400)) - 32'd13107200;
			default: return 32'($urandom_range(0, 65536 * 8)) - 32'd262144;
		endcase
	endfunction

	// driver: bursts with gaps, optional hold until drained
	always @(posedge clk) begin
		if (!(s_tvalid && !s_tready)) begin
			if (hold_sender || pending_items.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (burst_left == 0 && gap_left > 0) begin
				s_tvalid <= 1'b0;
				gap_left <= gap_left - 1;
			end else begin
				ctrl_item_t it;
				it = pending_items.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {it.measurement, it.setpoint};
				s_tuser <= it.cmd;
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 12);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// receiver stall pattern: alternating ready and stall runs
	always @(posedge clk) begin
		if (stall_phase == 0) begin
			stall_phase <= $urandom_range(1, 400);
			stall_len <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 250);
			m_tready <= 1'b1;
		end else begin
			stall_phase <= stall_phase - 1;
			m_tready <= (stall_phase > stall_len);
		end
	end

	// monitor: predict on input transaction, compare on output transaction
	always @(posedge clk) begin
		drive_res_t got, exp_res;
		if (s_tvalid && s_tready) begin
			expected_drives.push_back(predict_drive({s_tuser[0], s_tdata[31:0], s_tdata[63:32]}));
		end
		if (m_tvalid && m_tready) begin
			got.drive = m_tdata[29:0];
			got.clamped = m_tuser[0];
			if (expected_drives.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result drive=%h clamped=%b", got.drive, got.clamped);
			end else begin
				exp_res = expected_drives.pop_front();
				if (got.drive !== exp_res.drive || got.clamped !== exp_res.clamped) begin
					mismatches++;
					if (mismatches <= 10)
						$display("drive mismatch: expected %h/%b, got %h/%b",
							exp_res.drive, exp_res.clamped, got.drive, got.clamped);
				end
			end
		end
	end

	// watchdog on accepted transactions
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT && !stim_done) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_items.size() != 0 || s_tvalid || expected_drives.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [25:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			ladrc_pkg::CFG_STEP_SIZE:  c_h = 64'(val[15:0]);
			ladrc_pkg::CFG_TRACK_GAIN: c_r = 64'(val);
			ladrc_pkg::CFG_CTRL_BW:    c_wc = 64'(val);
			ladrc_pkg::CFG_OBS_BW:     c_w0 = 64'(val);
			ladrc_pkg::CFG_PLANT_GAIN: c_b0 = 64'(val);
			default: ;
		endcase
	endtask

	task automatic add_item(logic cmd, logic [31:0] sp, logic [31:0] ms);
		ctrl_item_t it;
		it.cmd = cmd;
		it.setpoint = sp;
		it.measurement = ms;
		pending_items.push_back(it);
	endtask

	task automatic random_items(int n);
		int mode;
		mode = $urandom_range(0, 2);
		repeat (n) begin
			if ($urandom_range(0, 19) == 0)
				add_item(CMD_CLEAR, $urandom, $urandom);
			else
				add_item(CMD_RUN, rand_word(mode), rand_word(mode));
		end
	endtask

	initial begin
		logic [25:0] cfg_sets[5][5];
		int waited;
		m_rpos = 0; m_rvel = 0; m_epos = 0; m_evel = 0; m_edist = 0; m_last = 0;
		c_h = 66; c_r = 1310720; c_wc = 2162688; c_w0 = 8716288; c_b0 = 524288;
		// step, r, wc, w0, b0 per phase, extremes included
		cfg_sets[0] = '{26'd66, 26'd1310720, 26'd2162688, 26'd8716288, 26'd524288};
		cfg_sets[1] = '{26'd1, 26'd0, 26'd0, 26'd0, 26'd1};
		cfg_sets[2] = '{26'd65535, 26'h3FFFFFF, 26'h3FFFFFF, 26'h3FFFFFF, 26'h3FFFFFF};
		cfg_sets[3] = '{26'd655, 26'd655360, 26'd655360, 26'd2621440, 26'd0};
		cfg_sets[4] = '{26'd6553, 26'd3276800, 26'd1310720, 26'd6553600, 26'd65536};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: reset configuration, field extremes and clears
		add_item(CMD_RUN, 32'h0, 32'h0);
		add_item(CMD_RUN, 32'h7FFFFFFF, 32'h80000000);
		add_item(CMD_RUN, 32'h80000000, 32'h7FFFFFFF);
		add_item(CMD_RUN, 32'hFFFFFFFF, 32'hFFFFFFFF);
		add_item(CMD_CLEAR, 32'hFFFFFFFF, 32'hFFFFFFFF);
		add_item(CMD_RUN, 32'h00010000, 32'h0);
		add_item(CMD_RUN, 32'h00640000, 32'h0);
		add_item(CMD_CLEAR, 32'h0, 32'h0);
		add_item(CMD_RUN, 32'h55555555, 32'hAAAAAAAA);
		add_item(CMD_RUN, 32'hAAAAAAAA, 32'h55555555);
		// sender holds mid-run until every outstanding result is back
		repeat (700) @(posedge clk);
		hold_sender = 1;
		while (s_tvalid || expected_drives.size() != 0)
			@(posedge clk);
		hold_sender = 0;
		wait_drained();

		// zero gains with a plant gain of one
		write_reg(ladrc_pkg::CFG_STEP_SIZE, 26'd0 + 26'd1);
		write_reg(ladrc_pkg::CFG_TRACK_GAIN, 26'd0);
		write_reg(ladrc_pkg::CFG_CTRL_BW, 26'd0);
		write_reg(ladrc_pkg::CFG_OBS_BW, 26'd0);
		write_reg(ladrc_pkg::CFG_PLANT_GAIN, 26'd65536);
		add_item(CMD_RUN, 32'h0, 32'h0);
		add_item(CMD_CLEAR, 32'h0, 32'h0);
		wait_drained();

		for (int ph = 0; ph < 10; ph++) begin
			for (int k = 0; k < 5; k++)
				write_reg(3'(k), (ph < 5) ? cfg_sets[ph][k] : 26'($urandom));
			if (ph >= 5) write_reg(ladrc_pkg::CFG_STEP_SIZE, 26'($urandom_range(1, 2000)));
			random_items(143);
			// one phase waits fully drained before the next write
			wait_drained();
		end
		write_reg(3'd7, 26'h3FFFFFF);
		random_items(10);
		wait_drained();

		stim_done = 1;
		waited = 0;
		while (expected_drives.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (300) @(posedge clk);
		if (mismatches == 0 && expected_drives.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
